// ----- rtl/agal_pkg.sv -----
// Package for the affine gap last-row alignment scorer.
// Holds payload structs, register indexes, actions and the controller/datapath command struct.
package agal_pkg;
   localparam int MaxRefLen   = 1024;
   localparam int MaxQueryLen = 65535;
   localparam int ScoreBits   = 24;
   localparam int GapStart    = -1000;
   localparam int PosBits     = 11;
   localparam int OutBits     = 24;

   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_QUERY  = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam logic [1:0] REG_GAP_OPEN  = 2'd0;
   localparam logic [1:0] REG_GAP_EXT   = 2'd1;
   localparam logic [1:0] REG_MATCH     = 2'd2;
   localparam logic [1:0] REG_MISMATCH  = 2'd3;

   typedef struct packed {
      logic [1:0]         action;
      logic [7:0]         symbol;
      logic [PosBits-1:0] position;
   } req_payload_type;

   typedef struct packed {
      logic signed [OutBits-1:0] score;
      logic                      bad_index;
   } rsp_payload_type;

   // controller to datapath commands
   typedef struct packed {
      logic row_start;   // latch row-start values for the query
      logic cell_issue;  // issue memory reads for column j
      logic cell_exec;   // compute and write column j
      logic row_end;     // write column zero
      logic read_issue;  // issue read of best row
      logic read_done;   // capture response
   } agal_cmd_type;
endpackage

// ----- rtl/agal_ram.sv -----
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module agal_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- rtl/agal_datapath.sv -----
// Datapath: reference and row stores, column recurrences and saturation.
// Depends on agal_pkg and agal_ram.
module agal_datapath
   import agal_pkg::*;
#(
   parameter int MAX_REF_LEN = MaxRefLen,
   parameter int SCORE_BITS  = ScoreBits,
   localparam int AW = $clog2(MAX_REF_LEN + 1),
   localparam int RW = $clog2(MAX_REF_LEN)
) (
   input  logic                    clock,
   input  agal_cmd_type            cmd,
   input  logic [AW-1:0]           col,
   input  logic                    rows_zero,
   input  logic [23:0]             row_index,
   input  logic                    load_en,
   input  logic [RW-1:0]           load_addr,
   input  logic [7:0]              load_symbol,
   input  logic [7:0]              query_symbol,
   input  logic [AW-1:0]           read_addr,
   input  logic                    read_bad,
   input  logic signed [7:0]       gap_open,
   input  logic signed [7:0]       gap_ext,
   input  logic signed [7:0]       match_bonus,
   input  logic signed [7:0]       mismatch_cost,
   output rsp_payload_type         rsp_data
);
   localparam int WB = ((SCORE_BITS > 24) ? SCORE_BITS : 24) + 10;
   localparam logic signed [WB-1:0] SatHi = WB'((64'sd1 <<< (SCORE_BITS - 1)) - 1);
   localparam logic signed [WB-1:0] SatLo = -SatHi - WB'(1);
   localparam logic signed [WB-1:0] Start = WB'(GapStart);

   function automatic logic signed [WB-1:0] sat(input logic signed [WB-1:0] v);
      if (v > SatHi) begin
         return SatHi;
      end else if (v < SatLo) begin
         return SatLo;
      end
      return v;
   endfunction

   function automatic logic signed [WB-1:0] max2(input logic signed [WB-1:0] a,
                                                 input logic signed [WB-1:0] b);
      return (a > b) ? a : b;
   endfunction

   logic [7:0]                 ref_rd;
   logic [SCORE_BITS-1:0]      d_rd, q_rd;
   logic                       d_we, q_we;
   logic [AW-1:0]              w_addr, d_raddr;
   logic [SCORE_BITS-1:0]      d_wdata, q_wdata;
   logic signed [WB-1:0]       p_ff, p_in, left_ff, left_in, diag_ff, diag_in;
   logic signed [WB-1:0]       old_d, old_q, gap_mul_ff, gap_mul_in, col_gap_ff;
   logic signed [WB-1:0]       s, p, q, d, go_ge;
   logic signed [WB-1:0]       lead_ff;
   rsp_payload_type            rsp_ff, rsp_in;
   logic [RW-1:0]              ref_raddr;
   logic [AW-1:0]              j_ff;

   agal_ram #(.WIDTH(8), .DEPTH(MAX_REF_LEN)) u_ref (
      .clock, .wr_en(load_en), .wr_addr(load_addr), .wr_data(load_symbol),
      .rd_addr(ref_raddr), .rd_data(ref_rd));
   agal_ram #(.WIDTH(SCORE_BITS), .DEPTH(MAX_REF_LEN + 1)) u_best (
      .clock, .wr_en(d_we), .wr_addr(w_addr), .wr_data(d_wdata),
      .rd_addr(d_raddr), .rd_data(d_rd));
   agal_ram #(.WIDTH(SCORE_BITS), .DEPTH(MAX_REF_LEN + 1)) u_vgap (
      .clock, .wr_en(q_we), .wr_addr(w_addr), .wr_data(q_wdata),
      .rd_addr(col), .rd_data(q_rd));

   assign ref_raddr = RW'(col - AW'(1));
   assign d_raddr   = cmd.read_issue ? read_addr : col;
   assign go_ge     = WB'(gap_open) + WB'(gap_ext);
   // gap formula term for the column being computed (registered product)
   assign gap_mul_in = sat(WB'(gap_open) + WB'(signed'({1'b0, col})) * WB'(gap_ext));

   always_comb begin
      old_d = rows_zero ? col_gap_ff : WB'(signed'(d_rd));
      old_q = rows_zero ? Start : WB'(signed'(q_rd));
      s     = (ref_rd == query_symbol) ? WB'(match_bonus) : WB'(mismatch_cost);
      p     = sat(max2(p_ff + WB'(gap_ext), left_ff + go_ge));
      q     = sat(max2(old_q + WB'(gap_ext), old_d + go_ge));
      d     = sat(max2(diag_ff + s, max2(p, q)));
      p_in = p_ff;
      left_in = left_ff;
      diag_in = diag_ff;
      d_we = 1'b0;
      q_we = 1'b0;
      w_addr = j_ff;
      d_wdata = d[SCORE_BITS-1:0];
      q_wdata = q[SCORE_BITS-1:0];
      if (cmd.row_start) begin
         p_in = Start;
         left_in = lead_ff;
         diag_in = rows_zero ? '0 : WB'(signed'(d_rd));
      end
      if (cmd.cell_exec) begin
         d_we = 1'b1;
         q_we = 1'b1;
         p_in = p;
         left_in = d;
         diag_in = old_d;
      end
      if (cmd.row_end) begin
         d_we = 1'b1;
         q_we = 1'b1;
         w_addr = '0;
         d_wdata = lead_ff[SCORE_BITS-1:0];
         q_wdata = Start[SCORE_BITS-1:0];
      end
      rsp_in = rsp_ff;
      if (cmd.read_done) begin
         rsp_in.bad_index = read_bad;
         if (read_bad) begin
            rsp_in.score = '0;
         end else if (rows_zero) begin
            rsp_in.score = (j_ff == '0) ? '0 : OutBits'(col_gap_ff);
         end else begin
            rsp_in.score = OutBits'(signed'(d_rd));
         end
      end
   end

   always_ff @(posedge clock) begin
      gap_mul_ff <= gap_mul_in;
      col_gap_ff <= gap_mul_ff;
      lead_ff    <= sat(WB'(gap_open) + WB'(signed'({1'b0, row_index})) * WB'(gap_ext));
      j_ff       <= col;
      p_ff       <= p_in;
      left_ff    <= left_in;
      diag_ff    <= diag_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_data = rsp_ff;
endmodule

// ----- rtl/agal_controller.sv -----
// Controller: request decode, column sequencing and response handshake.
// Depends on agal_pkg.
module agal_controller
   import agal_pkg::*;
#(
   parameter int MAX_REF_LEN   = MaxRefLen,
   parameter int MAX_QUERY_LEN = MaxQueryLen,
   localparam int AW = $clog2(MAX_REF_LEN + 1),
   localparam int RW = $clog2(MAX_REF_LEN)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output agal_cmd_type    cmd,
   output logic [AW-1:0]   col,
   output logic            rows_zero,
   output logic [23:0]     row_index,
   output logic            load_en,
   output logic [RW-1:0]   load_addr,
   output logic [7:0]      load_symbol,
   output logic [7:0]      query_symbol,
   output logic [AW-1:0]   read_addr,
   output logic            read_bad
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_LEAD, ST_START, ST_ISSUE, ST_WAIT, ST_EXEC, ST_READ, ST_RSP
   } state_type;

   state_type     state_ff;
   logic [AW-1:0] len_ff, col_ff, rdpos_ff;
   logic [23:0]   rows_ff;
   logic [7:0]    sym_ff;
   logic          bad_ff, rsp_valid_ff;
   logic [2:0]    wait_ff;
   logic          accept;

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign col       = col_ff;
   assign rows_zero = (rows_ff == '0);
   assign row_index = rows_ff + 24'd1;
   assign load_en   = accept && (req_data.action == ACT_LOAD) &&
                      (32'(req_data.position) < MAX_REF_LEN);
   assign load_addr = RW'(req_data.position);
   assign load_symbol = req_data.symbol;
   assign query_symbol = sym_ff;
   assign read_addr = rdpos_ff;
   assign read_bad  = bad_ff;

   always_comb begin
      cmd = '0;
      cmd.row_start  = (state_ff == ST_START);
      cmd.cell_exec  = (state_ff == ST_EXEC);
      cmd.row_end    = (state_ff == ST_START);
      cmd.cell_issue = (state_ff == ST_ISSUE);
      cmd.read_issue = (state_ff == ST_READ) && (wait_ff == '0);
      cmd.read_done  = (state_ff == ST_READ) && (wait_ff == 3'd3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff <= '0;
         rows_ff <= '0;
         col_ff <= '0;
         rsp_valid_ff <= 1'b0;
         wait_ff <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  sym_ff <= req_data.symbol;
                  case (req_data.action)
                     ACT_LOAD: begin
                        if (load_en) begin
                           if (req_data.position == '0) begin
                              rows_ff <= '0;
                              len_ff <= AW'(1);
                           end else if (AW'(req_data.position) >= len_ff) begin
                              len_ff <= AW'(req_data.position) + AW'(1);
                           end
                        end
                     end
                     ACT_QUERY: begin
                        if (32'(rows_ff) < MAX_QUERY_LEN) begin
                           col_ff <= '0;
                           wait_ff <= '0;
                           state_ff <= ST_LEAD;
                        end
                     end
                     ACT_READ: begin
                        bad_ff <= 32'(req_data.position) > 32'(len_ff);
                        rdpos_ff <= AW'(req_data.position);
                        col_ff <= AW'(req_data.position);
                        wait_ff <= '0;
                        state_ff <= ST_READ;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_LEAD: begin
               // let row-start product and column zero read settle
               wait_ff <= wait_ff + 3'd1;
               if (wait_ff == 3'd2) begin
                  state_ff <= ST_START;
               end
            end
            ST_START: begin
               if (len_ff == '0) begin
                  rows_ff <= rows_ff + 24'd1;
                  state_ff <= ST_IDLE;
               end else begin
                  col_ff <= AW'(1);
                  wait_ff <= '0;
                  state_ff <= ST_ISSUE;
               end
            end
            ST_ISSUE: begin
               wait_ff <= '0;
               state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               wait_ff <= wait_ff + 3'd1;
               if (wait_ff == 3'd0) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (col_ff >= len_ff) begin
                  rows_ff <= rows_ff + 24'd1;
                  state_ff <= ST_IDLE;
               end else begin
                  col_ff <= col_ff + AW'(1);
                  state_ff <= ST_ISSUE;
               end
            end
            ST_READ: begin
               wait_ff <= wait_ff + 3'd1;
               if (wait_ff == 3'd3) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff <= ST_RSP;
               end
            end
            ST_RSP: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.action == ACT_READ) |=> !req_ready)
      else $error("ready held after read accept");
   assert property (@(posedge clock) disable iff (reset) cmd.cell_exec |-> col_ff != '0)
      else $error("column zero computed as cell");
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> state_ff == ST_RSP)
      else $error("response outside read");
endmodule

// ----- rtl/affine_gap_alignment_last_row.sv -----
// Top level of the affine gap last-row alignment scorer.
// Channels: req (valid/ready, req_payload_type) carries load, query and read requests;
// rsp (valid/ready, rsp_payload_type) returns one result per read request.
// csr: APB-style port, four 8-bit signed registers at 0,4,8,12; pready always high.
// A query steps each column through the issue, wait and exec states, paced by the
// registered RAM read loop.
// One request is worked on at a time; ready stays low while a request is in progress
// or a response waits. A stalled receiver holds the response and further requests.
// Reset (synchronous) clears length, row count and registers to defaults; the
// stores need no clearing pass: the first row uses the gap formula.
// Depends on agal_pkg, agal_controller, agal_datapath, agal_ram.
module affine_gap_alignment_last_row
   import agal_pkg::*;
#(
   parameter int MAX_REF_LEN   = MaxRefLen,
   parameter int MAX_QUERY_LEN = MaxQueryLen,
   parameter int SCORE_BITS    = ScoreBits
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            psel,
   input  logic            penable,
   input  logic            pwrite,
   input  logic [3:0]      paddr,
   input  logic [31:0]     pwdata,
   output logic [31:0]     prdata,
   output logic            pready
);
   localparam int AW = $clog2(MAX_REF_LEN + 1);
   localparam int RW = $clog2(MAX_REF_LEN);

   logic signed [7:0] go_ff, ge_ff, mb_ff, mc_ff;
   agal_cmd_type      cmd;
   logic [AW-1:0]     col, read_addr;
   logic              rows_zero, load_en, read_bad;
   logic [23:0]       row_index;
   logic [RW-1:0]     load_addr;
   logic [7:0]        load_symbol, query_symbol;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         go_ff <= -8'sd2;
         ge_ff <= -8'sd1;
         mb_ff <= 8'sd1;
         mc_ff <= -8'sd2;
      end else if (psel && penable && pwrite) begin
         case (paddr[3:2])
            REG_GAP_OPEN: go_ff <= pwdata[7:0];
            REG_GAP_EXT:  ge_ff <= pwdata[7:0];
            REG_MATCH:    mb_ff <= pwdata[7:0];
            REG_MISMATCH: mc_ff <= pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_GAP_OPEN: prdata = 32'(signed'(go_ff));
         REG_GAP_EXT:  prdata = 32'(signed'(ge_ff));
         REG_MATCH:    prdata = 32'(signed'(mb_ff));
         REG_MISMATCH: prdata = 32'(signed'(mc_ff));
         default:      prdata = '0;
      endcase
   end

   agal_controller #(.MAX_REF_LEN(MAX_REF_LEN), .MAX_QUERY_LEN(MAX_QUERY_LEN)) u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .cmd, .col, .rows_zero, .row_index, .load_en, .load_addr, .load_symbol,
      .query_symbol, .read_addr, .read_bad);

   agal_datapath #(.MAX_REF_LEN(MAX_REF_LEN), .SCORE_BITS(SCORE_BITS)) u_dp (
      .clock, .cmd, .col, .rows_zero, .row_index, .load_en, .load_addr, .load_symbol,
      .query_symbol, .read_addr, .read_bad, .gap_open(go_ff), .gap_ext(ge_ff),
      .match_bonus(mb_ff), .mismatch_cost(mc_ff), .rsp_data);
endmodule
